// ===== hw/rtl/virtual_time_timer_queue_top_macros.svh =====
// -----------------------------------------------------------------------------
// Timer queue assertion macros
// Shared concurrent assertion wrappers on clock and reset.
// -----------------------------------------------------------------------------
`ifndef VIRTUAL_TIME_TIMER_QUEUE_TOP_MACROS_SVH
`define VIRTUAL_TIME_TIMER_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define VTTQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer queue assertion failed");

// next-cycle implication
`define VTTQ_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer queue assertion failed");

`endif

// ===== hw/rtl/vttq_pkg.sv =====
// -----------------------------------------------------------------------------
// Timer queue package
// Opcodes, status codes, state type and saturating time arithmetic.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vttq_pkg;

   localparam int REQ_W       = 80;
   localparam int RSP_W       = 72;
   localparam int CSR_DW      = 63;
   localparam int TIME_W      = 64;
   localparam int MAX_RESULTS = 16;
   localparam int NCNT_W      = 5;

   localparam logic signed [TIME_W-1:0] TIME_POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [TIME_W-1:0] TIME_NEG_MIN = 64'sh8000_0000_0000_0000;

   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_CANCEL = 3'd1;
   localparam logic [2:0] OP_SET    = 3'd2;
   localparam logic [2:0] OP_INC    = 3'd3;
   localparam logic [2:0] OP_RUN    = 3'd4;
   localparam logic [2:0] OP_FLUSH  = 3'd5;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_CANCELLED = 2'd1;
   localparam logic [1:0] ST_IGNORED   = 2'd2;
   localparam logic [1:0] ST_FIRED     = 2'd3;

   localparam logic CSR_TL_IN_USE = 1'b0;
   localparam logic CSR_CLK_START = 1'b1;

   localparam logic [2:0] TL_IN_USE_RESET = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   function automatic logic signed [TIME_W-1:0] sat_add(
      input logic signed [TIME_W-1:0] a,
      input logic signed [TIME_W-1:0] b
   );
      logic signed [TIME_W-1:0] s;
      s = a + b;
      if (a[TIME_W-1] == b[TIME_W-1] && s[TIME_W-1] != a[TIME_W-1]) begin
         s = b[TIME_W-1] ? TIME_NEG_MIN : TIME_POS_MAX;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/vttq_ram.sv =====
// -----------------------------------------------------------------------------
// Timer queue RAM
// Generic single-write, single-read memory with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vttq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/virtual_time_timer_queue_top.sv =====
// Start, cancel and clock ops make one RAM scan. Run and flush make one full expiry
// RAM scan through the single read port per fired slot, plus a final scan.
// One item at a time; a finished result waits in the output register.
// Reset (synchronous) disarms all slots, zeroes timeline clocks, in-use = 4.
// -----------------------------------------------------------------------------
// Virtual-time timer queue
// Per-timeline clocks and one-shot timer slots with expiry kept in RAM.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "virtual_time_timer_queue_top_macros.svh"

module virtual_time_timer_queue_top #(
   parameter int TIMER_SLOTS = 16,
   parameter int TIMELINES   = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // opcode[2:0], timeline[4:3], timer_slot[8:5], relative[9], time_value[73:10]
   input  logic [vttq_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[1:0], fired_valid[2], fired_slot[6:3], next_expiry[70:7]
   output logic [vttq_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [vttq_pkg::CSR_DW-1:0] csr_wdata
);

   localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int TW = (TIMELINES > 1) ? $clog2(TIMELINES) : 1;
   localparam int W  = vttq_pkg::TIME_W;

   vttq_pkg::state_type state_ff;

   logic [2:0]          op_ff;
   logic [1:0]          t_ff;
   logic [3:0]          slot_ff;
   logic                rel_ff;
   logic signed [W-1:0] val_ff;
   logic                bad_ff;
   logic [2:0]          tiu_ff;

   logic signed [W-1:0] clk_ff [TIMELINES];
   logic                armed_ff [TIMER_SLOTS];
   logic [1:0]          tag_ff [TIMER_SLOTS];

   logic [CW-1:0]       cnt_ff;
   logic                rdv_ff;
   logic [SW-1:0]       rdi_ff;
   logic                first_ff;
   logic                nv_ff;
   logic signed [W-1:0] nmin_ff;
   logic                bv_ff;
   logic signed [W-1:0] bexp_ff;
   logic [SW-1:0]       bidx_ff;
   logic [vttq_pkg::NCNT_W-1:0] n_ff;
   logic                pv_ff;
   logic [SW-1:0]       pslot_ff;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic                rsp_fv_ff;
   logic [3:0]          rsp_slot_ff;
   logic signed [W-1:0] rsp_next_ff;
   logic                rsp_last_ff;

   logic signed [W-1:0] cur_clk;
   logic signed [W-1:0] rd_data;
   logic signed [W-1:0] wr_data_in;
   logic [SW-1:0]       s_idx;
   logic [TW-1:0]       t_idx;
   logic                slot_ok;
   logic                elig;
   logic                lim_ok;
   logic                out_free;
   logic                run_op;
   logic                found;
   logic                push;
   logic                advance;
   logic                finish;
   logic                ram_we;
   logic [1:0]          res_status;
   logic                res_fv;
   logic [3:0]          res_slot;
   logic                res_last;
   logic signed [W-1:0] next_out;

   assign t_idx    = TW'(t_ff);
   assign s_idx    = SW'(slot_ff);
   assign cur_clk  = clk_ff[t_idx];
   assign slot_ok  = 32'(slot_ff) < TIMER_SLOTS;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign run_op   = !bad_ff && (op_ff == vttq_pkg::OP_RUN || op_ff == vttq_pkg::OP_FLUSH);
   assign found    = bv_ff && (32'(n_ff) < vttq_pkg::MAX_RESULTS);
   assign next_out = nv_ff ? nmin_ff : '0;
   assign elig     = armed_ff[rdi_ff] && (tag_ff[rdi_ff] == t_ff);
   assign lim_ok   = (op_ff == vttq_pkg::OP_FLUSH) || (rd_data <= cur_clk);
   assign wr_data_in = rel_ff ? vttq_pkg::sat_add(cur_clk, val_ff) : val_ff;

   assign req_tready = (state_ff == vttq_pkg::S_IDLE);

   always_comb begin
      push       = 1'b0;
      advance    = 1'b0;
      finish     = 1'b0;
      res_status = vttq_pkg::ST_DONE;
      res_fv     = 1'b0;
      res_slot   = '0;
      res_last   = 1'b1;
      if (state_ff == vttq_pkg::S_DONE) begin
         if (bad_ff) begin
            push       = out_free;
            finish     = out_free;
            res_status = vttq_pkg::ST_IGNORED;
         end else if (run_op) begin
            if (found) begin
               push       = pv_ff && out_free;
               advance    = !pv_ff || out_free;
               res_status = vttq_pkg::ST_FIRED;
               res_fv     = 1'b1;
               res_slot   = 4'(pslot_ff);
               res_last   = 1'b0;
            end else begin
               push   = out_free;
               finish = out_free;
               if (pv_ff) begin
                  res_status = vttq_pkg::ST_FIRED;
                  res_fv     = 1'b1;
                  res_slot   = 4'(pslot_ff);
               end
            end
         end else begin
            push   = out_free;
            finish = out_free;
            case (op_ff) inside
               vttq_pkg::OP_START:
                  res_status = slot_ok ? vttq_pkg::ST_DONE : vttq_pkg::ST_IGNORED;
               vttq_pkg::OP_CANCEL:
                  res_status = !slot_ok ? vttq_pkg::ST_IGNORED :
                               armed_ff[s_idx] ? vttq_pkg::ST_CANCELLED : vttq_pkg::ST_DONE;
               vttq_pkg::OP_SET, vttq_pkg::OP_INC:
                  res_status = (val_ff <= 0) ? vttq_pkg::ST_IGNORED : vttq_pkg::ST_DONE;
               default:
                  res_status = vttq_pkg::ST_IGNORED;
            endcase
         end
      end
   end

   assign ram_we = finish && !bad_ff && !run_op && op_ff == vttq_pkg::OP_START && slot_ok;

   vttq_ram #(
      .WIDTH (W),
      .DEPTH (TIMER_SLOTS)
   ) u_expiry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s_idx),
      .wr_data (wr_data_in),
      .rd_addr (cnt_ff[SW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vttq_pkg::S_IDLE;
         tiu_ff       <= vttq_pkg::TL_IN_USE_RESET;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         n_ff         <= '0;
         bv_ff        <= 1'b0;
         nv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         // clocks reset to zero
         for (int i = 0; i < TIMELINES; i++) begin
            clk_ff[i] <= '0;
         end
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            armed_ff[i] <= 1'b0;
            tag_ff[i]   <= '0;
         end
      end else begin
         if (csr_we && csr_index == vttq_pkg::CSR_TL_IN_USE) begin
            tiu_ff <= csr_wdata[2:0];
         end

         if (push) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= res_status;
            rsp_fv_ff     <= res_fv;
            rsp_slot_ff   <= res_slot;
            rsp_next_ff   <= next_out;
            rsp_last_ff   <= res_last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            vttq_pkg::S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tdata[2:0];
                  t_ff     <= req_tdata[4:3];
                  slot_ff  <= req_tdata[8:5];
                  rel_ff   <= req_tdata[9];
                  val_ff   <= req_tdata[73:10];
                  bad_ff   <= !(req_tdata[4:3] < tiu_ff && 32'(req_tdata[4:3]) < TIMELINES);
                  nv_ff    <= 1'b0;
                  bv_ff    <= 1'b0;
                  pv_ff    <= 1'b0;
                  n_ff     <= '0;
                  first_ff <= 1'b1;
                  cnt_ff   <= '0;
                  rdv_ff   <= 1'b0;
                  state_ff <= (req_tdata[4:3] < tiu_ff && 32'(req_tdata[4:3]) < TIMELINES)
                              ? vttq_pkg::S_SCAN : vttq_pkg::S_DONE;
               end
            end
            vttq_pkg::S_SCAN: begin
               if (cnt_ff < CW'(TIMER_SLOTS)) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               rdv_ff <= cnt_ff < CW'(TIMER_SLOTS);
               rdi_ff <= cnt_ff[SW-1:0];
               if (rdv_ff) begin
                  if (first_ff && elig && (!nv_ff || rd_data < nmin_ff)) begin
                     nv_ff   <= 1'b1;
                     nmin_ff <= rd_data;
                  end
                  if (elig && lim_ok && (!bv_ff || rd_data < bexp_ff)) begin
                     bv_ff   <= 1'b1;
                     bexp_ff <= rd_data;
                     bidx_ff <= rdi_ff;
                  end
                  if (rdi_ff == SW'(TIMER_SLOTS - 1)) begin
                     state_ff <= vttq_pkg::S_DONE;
                  end
               end
            end
            vttq_pkg::S_DONE: begin
               if (advance) begin
                  armed_ff[bidx_ff] <= 1'b0;
                  pv_ff    <= 1'b1;
                  pslot_ff <= bidx_ff;
                  n_ff     <= n_ff + 1'b1;
                  bv_ff    <= 1'b0;
                  first_ff <= 1'b0;
                  cnt_ff   <= '0;
                  rdv_ff   <= 1'b0;
                  state_ff <= vttq_pkg::S_SCAN;
               end else if (finish) begin
                  state_ff <= vttq_pkg::S_IDLE;
                  if (!bad_ff && !run_op) begin
                     case (op_ff)
                        vttq_pkg::OP_START: begin
                           if (slot_ok) begin
                              armed_ff[s_idx] <= 1'b1;
                              tag_ff[s_idx]   <= t_ff;
                           end
                        end
                        vttq_pkg::OP_CANCEL: begin
                           if (slot_ok) begin
                              armed_ff[s_idx] <= 1'b0;
                           end
                        end
                        vttq_pkg::OP_SET: begin
                           if (val_ff > 0) begin
                              clk_ff[t_idx] <= val_ff;
                           end
                        end
                        vttq_pkg::OP_INC: begin
                           if (val_ff > 0) begin
                              clk_ff[t_idx] <= vttq_pkg::sat_add(cur_clk, val_ff);
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            default: state_ff <= vttq_pkg::S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_next_ff, rsp_slot_ff, rsp_fv_ff, rsp_status_ff};

   `VTTQ_ASSERT_IMP(a_fire_cap, 1'b1, 32'(n_ff) <= vttq_pkg::MAX_RESULTS)
   `VTTQ_ASSERT_IMP(a_best_armed, state_ff == vttq_pkg::S_SCAN && bv_ff, armed_ff[bidx_ff])
   `VTTQ_ASSERT_NXT(a_busy_after_xfer, req_tvalid && req_tready, state_ff != vttq_pkg::S_IDLE)

endmodule

// ===== sim/virtual_time_timer_queue_top_tb.sv =====
// -----------------------------------------------------------------------------
// Timer queue testbench
// Drives start, cancel, clock, run, flush and invalid requests through the request
// stream with random gaps and output stalls. A scoreboard keeps its own copy of
// the timeline clocks and timer slots, predicts every response and checks each
// response transfer field by field in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module virtual_time_timer_queue_top_tb;

   typedef logic signed [vttq_pkg::TIME_W-1:0] time_val_type;

   typedef struct packed {
      logic [1:0]   status;
      logic         fired_valid;
      logic [3:0]   fired_slot;
      time_val_type next_expiry;
      logic         last;
   } timer_rsp_type;

   class timer_queue_scoreboard;
      int            errors;
      timer_rsp_type expected_q[$];
      logic [2:0]    tl_in_use;
      time_val_type  tl_clock[4];
      time_val_type  expiry[16];
      bit            armed[16];
      logic [1:0]    slot_tl[16];

      function new();
         errors    = 0;
         tl_in_use = vttq_pkg::TL_IN_USE_RESET;
         for (int i = 0; i < 4; i++) tl_clock[i] = '0;
         for (int i = 0; i < 16; i++) begin
            expiry[i]  = '0;
            armed[i]   = 0;
            slot_tl[i] = '0;
         end
      endfunction

      function time_val_type clamp_add(time_val_type a, time_val_type b);
         logic signed [vttq_pkg::TIME_W:0] wide;
         wide = $signed({a[vttq_pkg::TIME_W-1], a}) + $signed({b[vttq_pkg::TIME_W-1], b});
         if (wide > $signed({1'b0, vttq_pkg::TIME_POS_MAX})) return vttq_pkg::TIME_POS_MAX;
         if (wide < $signed({1'b1, vttq_pkg::TIME_NEG_MIN})) return vttq_pkg::TIME_NEG_MIN;
         return wide[vttq_pkg::TIME_W-1:0];
      endfunction

      function int earliest(logic [1:0] t, bit limited, time_val_type lim);
         int best;
         best = -1;
         for (int i = 0; i < 16; i++) begin
            if (!armed[i] || slot_tl[i] != t) continue;
            if (limited && expiry[i] > lim) continue;
            if (best < 0 || expiry[i] < expiry[best]) best = i;
         end
         return best;
      endfunction

      function void push(logic [1:0] st, logic fv, logic [3:0] fs, time_val_type nx,
                         logic lst);
         timer_rsp_type r;
         r.status      = st;
         r.fired_valid = fv;
         r.fired_slot  = fs;
         r.next_expiry = nx;
         r.last        = lst;
         expected_q.push_back(r);
      endfunction

      function void note_request(logic [vttq_pkg::REQ_W-1:0] d);
         logic [2:0]   op;
         logic [1:0]   t;
         logic [3:0]   slot;
         logic         rel;
         time_val_type val, nxt;
         int           first, s, n;
         op   = d[2:0];
         t    = d[4:3];
         slot = d[8:5];
         rel  = d[9];
         val  = d[73:10];
         nxt  = '0;
         n    = 0;
         if ({1'b0, t} >= tl_in_use) begin
            push(vttq_pkg::ST_IGNORED, 0, 0, '0, 1);
            return;
         end
         first = earliest(t, 0, '0);
         if (first >= 0) nxt = expiry[first];
         case (op) inside
            vttq_pkg::OP_START: begin
               expiry[slot]  = rel ? clamp_add(tl_clock[t], val) : val;
               armed[slot]   = 1;
               slot_tl[slot] = t;
               push(vttq_pkg::ST_DONE, 0, 0, nxt, 1);
            end
            vttq_pkg::OP_CANCEL: begin
               push(armed[slot] ? vttq_pkg::ST_CANCELLED : vttq_pkg::ST_DONE, 0, 0, nxt, 1);
               armed[slot] = 0;
            end
            vttq_pkg::OP_SET, vttq_pkg::OP_INC: begin
               if (val <= 0) begin
                  push(vttq_pkg::ST_IGNORED, 0, 0, nxt, 1);
               end else begin
                  tl_clock[t] = (op == vttq_pkg::OP_SET) ? val : clamp_add(tl_clock[t], val);
                  push(vttq_pkg::ST_DONE, 0, 0, nxt, 1);
               end
            end
            vttq_pkg::OP_RUN, vttq_pkg::OP_FLUSH: begin
               while (n < vttq_pkg::MAX_RESULTS) begin
                  s = earliest(t, op == vttq_pkg::OP_RUN, tl_clock[t]);
                  if (s < 0) break;
                  armed[s] = 0;
                  push(vttq_pkg::ST_FIRED, 1, s[3:0], nxt, 0);
                  n++;
               end
               if (n == 0) push(vttq_pkg::ST_DONE, 0, 0, nxt, 1);
               else expected_q[$].last = 1;
            end
            default: push(vttq_pkg::ST_IGNORED, 0, 0, nxt, 1);
         endcase
      endfunction

      function void check_result(logic [vttq_pkg::RSP_W-1:0] d, logic lst);
         timer_rsp_type got, exp_r;
         got.status      = d[1:0];
         got.fired_valid = d[2];
         got.fired_slot  = d[6:3];
         got.next_expiry = d[70:7];
         got.last        = lst;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response transfer %h last %b", $time, d, lst);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            errors++;
         end
         if (got.fired_valid !== exp_r.fired_valid) begin
            $display("%0t: fired_valid exp %b got %b", $time, exp_r.fired_valid,
                     got.fired_valid);
            errors++;
         end
         if (got.fired_slot !== exp_r.fired_slot) begin
            $display("%0t: fired_slot exp %0d got %0d", $time, exp_r.fired_slot,
                     got.fired_slot);
            errors++;
         end
         if (got.next_expiry !== exp_r.next_expiry) begin
            $display("%0t: next_expiry exp %0d got %0d", $time, exp_r.next_expiry,
                     got.next_expiry);
            errors++;
         end
         if (got.last !== exp_r.last) begin
            $display("%0t: last exp %b got %b", $time, exp_r.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          req_tvalid = 0;
   logic                          req_tready;
   logic [vttq_pkg::REQ_W-1:0]    req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 0;
   logic [vttq_pkg::RSP_W-1:0]    rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we = 0;
   logic                          csr_index = 0;
   logic [vttq_pkg::CSR_DW-1:0]   csr_wdata = '0;

   timer_queue_scoreboard sb = new();
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   virtual_time_timer_queue_top i_dut (.*);

   always #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("virtual_time_timer_queue_top_tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_request(logic [2:0] op, logic [1:0] t, logic [3:0] slot,
                               logic rel, time_val_type val);
      logic [vttq_pkg::REQ_W-1:0] d;
      d = {6'b0, val, rel, slot, t, op};
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(d);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [vttq_pkg::CSR_DW-1:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 0;
      @(posedge clock);
      if (idx == vttq_pkg::CSR_TL_IN_USE) sb.tl_in_use = val[2:0];
   endtask

   function automatic time_val_type rand_time(logic [1:0] t);
      int m;
      m = $urandom_range(99);
      if (m < 40) return sb.tl_clock[t] + $signed(64'($urandom_range(300))) - 100;
      if (m < 60) return time_val_type'($urandom_range(200));
      if (m < 70) return -$signed(64'($urandom_range(50)));
      if (m < 80) return vttq_pkg::TIME_POS_MAX - time_val_type'($urandom_range(3));
      if (m < 85) return vttq_pkg::TIME_NEG_MIN + time_val_type'($urandom_range(3));
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_request();
      int         p;
      logic [2:0] op;
      logic [1:0] t;
      p = $urandom_range(99);
      t = 2'($urandom_range(3));
      if (p < 32) op = vttq_pkg::OP_START;
      else if (p < 44) op = vttq_pkg::OP_CANCEL;
      else if (p < 52) op = vttq_pkg::OP_SET;
      else if (p < 68) op = vttq_pkg::OP_INC;
      else if (p < 87) op = vttq_pkg::OP_RUN;
      else if (p < 94) op = vttq_pkg::OP_FLUSH;
      else op = 3'($urandom_range(7));
      if (op == vttq_pkg::OP_START && $urandom_range(1)) begin
         send_request(op, t, 4'($urandom_range(15)), 1'b1,
                      $urandom_range(3) == 0 ? time_val_type'({$urandom(), $urandom()})
                                             : time_val_type'($urandom_range(200)));
      end else if (op == vttq_pkg::OP_INC && $urandom_range(3) != 0) begin
         send_request(op, t, 4'($urandom_range(15)), 1'($urandom_range(1)),
                      time_val_type'($urandom_range(80)));
      end else begin
         send_request(op, t, 4'($urandom_range(15)), 1'($urandom_range(1)), rand_time(t));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      write_csr(vttq_pkg::CSR_TL_IN_USE, 4);
      write_csr(vttq_pkg::CSR_CLK_START, '0);
      send_request(vttq_pkg::OP_RUN, 0, 0, 0, 0);
      send_request(vttq_pkg::OP_FLUSH, 1, 0, 0, 0);
      send_request(vttq_pkg::OP_START, 0, 0, 0, vttq_pkg::TIME_POS_MAX);
      send_request(vttq_pkg::OP_START, 0, 1, 0, vttq_pkg::TIME_NEG_MIN);
      send_request(vttq_pkg::OP_START, 0, 2, 0, 5);
      send_request(vttq_pkg::OP_START, 0, 3, 0, 5);
      send_request(vttq_pkg::OP_START, 0, 2, 0, 3);
      send_request(vttq_pkg::OP_START, 1, 15, 1, 10);
      send_request(vttq_pkg::OP_SET, 0, 0, 0, 0);
      send_request(vttq_pkg::OP_SET, 0, 0, 0, -1);
      send_request(vttq_pkg::OP_INC, 0, 0, 0, vttq_pkg::TIME_NEG_MIN);
      send_request(vttq_pkg::OP_INC, 0, 0, 0, 4);
      send_request(vttq_pkg::OP_RUN, 0, 0, 0, 0);
      send_request(vttq_pkg::OP_CANCEL, 0, 0, 0, 0);
      send_request(vttq_pkg::OP_CANCEL, 0, 0, 0, 0);
      send_request(vttq_pkg::OP_SET, 2, 0, 0, vttq_pkg::TIME_POS_MAX - 2);
      send_request(vttq_pkg::OP_INC, 2, 0, 0, vttq_pkg::TIME_POS_MAX);
      send_request(vttq_pkg::OP_START, 2, 4, 1, vttq_pkg::TIME_POS_MAX);
      send_request(vttq_pkg::OP_START, 2, 5, 1, vttq_pkg::TIME_NEG_MIN);
      send_request(3'd6, 3, 0, 0, 0);
      send_request(3'd7, 0, 0, 1, -1);
      send_request(vttq_pkg::OP_FLUSH, 2, 0, 0, 0);
      send_request(vttq_pkg::OP_FLUSH, 0, 0, 0, 0);
      for (int i = 0; i < 16; i++)
         send_request(vttq_pkg::OP_START, 3, i[3:0], 0, -$signed(64'(i % 3)));
      send_request(vttq_pkg::OP_RUN, 3, 0, 0, 0);
      drain();

      // sender gaps, heavy receiver stalls, single timeline
      write_csr(vttq_pkg::CSR_TL_IN_USE, 1);
      write_csr(vttq_pkg::CSR_CLK_START, {vttq_pkg::CSR_DW{1'b1}});
      req_idle_pct = 34;
      rsp_idle_pct = 72;
      repeat (110) random_request();
      drain();

      // swapped idling, long receiver hold-off
      write_csr(vttq_pkg::CSR_TL_IN_USE, 3);
      write_csr(vttq_pkg::CSR_CLK_START, 63'd12345);
      req_idle_pct = 72;
      rsp_idle_pct = 34;
      hold_requests++;
      repeat (110) random_request();
      drain();

      // full rate
      write_csr(vttq_pkg::CSR_TL_IN_USE, 2);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (50) random_request();
      drain();
      write_csr(vttq_pkg::CSR_TL_IN_USE, 4);
      repeat (60) random_request();
      drain();

      repeat (400) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("virtual_time_timer_queue_top_tb OK");
      end else begin
         $display("virtual_time_timer_queue_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vttq_pkg.sv
hw/rtl/vttq_ram.sv
hw/rtl/virtual_time_timer_queue_top.sv
sim/virtual_time_timer_queue_top_tb.sv
